[hw/rtl/i2c_register_read_sequencer_macros.svh]
// Assertion helpers used by the sequencer core (i2c_rrs_core.sv).
`ifndef I2C_REGISTER_READ_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_READ_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge, ignored while reset is held.
`define RRS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define RRS_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RRS_ASSERT(label, clk, rst_n, prop, msg)
`define RRS_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[hw/rtl/i2c_rrs_pkg.sv]
`timescale 1ns / 1ps

package i2c_rrs_pkg;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_EVENT = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ACK_NONE = 2'd0,
    ACK_ACK  = 2'd1,
    ACK_NACK = 2'd2
  } ack_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SENDREG = 3'd1,
    PH_RESTART = 3'd2,
    PH_DUMMY   = 3'd3,
    PH_READING = 3'd4
  } phase_t;

  typedef struct packed {
    func_t      func;
    logic [6:0] slave_addr;
    logic [7:0] start_reg;
    logic [7:0] read_len;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       start_cond;
    logic       restart_cond;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       receive_mode;
    ack_t       ack_ctrl;
    logic       stop_cond;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       busy_now;
  } res_t;

endpackage

[hw/rtl/i2c_register_read_sequencer.sv]
`timescale 1ns / 1ps
// I2C burst register read sequencer. Each input beat is either a read request
// (tuser 0: slave address, first register, length) or a byte-complete event from
// the bus controller (tuser 1, with the received byte); each beat yields exactly
// one result beat telling the controller what to do next (START, send byte,
// repeated START, switch to receive, ACK/NACK, STOP) and delivering received
// bytes with their index. tlast marks the beat that drives STOP. A request is
// refused (accepted = 0) while a burst is running or when the length is zero.
// One beat per clock is sustained while out_tready does not stall the output; a
// beat is captured in an input register, passes the combinational sequencer
// logic and is then loaded into the output register as the result beat.

module i2c_register_read_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slave_addr[6:0], start_reg[14:7], read_len[22:15], rx_byte[30:23], zero pad
  input  logic [i2c_rrs_pkg::InDataW-1:0]  in_tdata,
  // func[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // accepted[0], start_cond[1], restart_cond[2], send_valid[3], send_byte[11:4],
  // receive_mode[12], ack_ctrl[14:13], data_valid[15], data_byte[23:16],
  // data_index[31:24], busy_now[32], zero pad
  output logic [i2c_rrs_pkg::OutDataW-1:0] out_tdata,
  // stop_cond
  output logic                             out_tlast
);
  import i2c_rrs_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     out_ready;
  logic     step;
  res_t     res;

  // advance when a held beat meets room in the output register
  assign step = item_valid && out_ready;

  i2c_rrs_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take_i    (step),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  i2c_rrs_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .item_i (item),
    .res_o  (res)
  );

  i2c_rrs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (step),
    .res_i      (res),
    .ready_o    (out_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[hw/rtl/i2c_rrs_in_stage.sv]
`timescale 1ns / 1ps

module i2c_rrs_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // slave_addr[6:0], start_reg[14:7], read_len[22:15], rx_byte[30:23], zero pad
  input  logic [i2c_rrs_pkg::InDataW-1:0] in_tdata,
  // func[0]
  input  logic                           in_tuser,
  input  logic                           take_i,
  output logic                           valid_o,
  output i2c_rrs_pkg::in_item_t          item_o
);
  import i2c_rrs_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_tready = !valid_r || take_i;
  assign valid_o   = valid_r;
  assign item_o    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (take_i) begin
      valid_r <= 1'b0;
    end
  end

  // hold the beat until the core takes it
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func       <= func_t'(in_tuser);
      item_r.slave_addr <= in_tdata[6:0];
      item_r.start_reg  <= in_tdata[14:7];
      item_r.read_len   <= in_tdata[22:15];
      item_r.rx_byte    <= in_tdata[30:23];
    end
  end

endmodule

[hw/rtl/i2c_rrs_core.sv]
`timescale 1ns / 1ps
`include "i2c_register_read_sequencer_macros.svh"

module i2c_rrs_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  i2c_rrs_pkg::in_item_t item_i,
  output i2c_rrs_pkg::res_t     res_o
);
  import i2c_rrs_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [6:0] target_addr_r, target_addr_nxt;
  logic [7:0] register_addr_r, register_addr_nxt;
  logic [7:0] burst_length_r, burst_length_nxt;
  logic [7:0] byte_position_r, byte_position_nxt;

  logic       req_ok;
  logic       last_byte;
  logic       arm_nack;
  logic [7:0] len_m1;
  logic [7:0] len_m2;

  assign len_m1    = burst_length_r - 8'd1;
  assign len_m2    = burst_length_r - 8'd2;
  assign req_ok    = (phase_r == PH_IDLE) && (item_i.read_len != 8'd0);
  assign last_byte = (burst_length_r == 8'd0) || (byte_position_r >= len_m1);
  assign arm_nack  = (burst_length_r >= 8'd2) && (byte_position_r == len_m2);

  // next state
  always_comb begin
    phase_nxt         = phase_r;
    target_addr_nxt   = target_addr_r;
    register_addr_nxt = register_addr_r;
    burst_length_nxt  = burst_length_r;
    byte_position_nxt = byte_position_r;
    if (item_i.func == FUNC_START) begin
      if (req_ok) begin
        target_addr_nxt   = item_i.slave_addr;
        register_addr_nxt = item_i.start_reg;
        burst_length_nxt  = item_i.read_len;
        byte_position_nxt = 8'd0;
        phase_nxt         = PH_SENDREG;
      end
    end else begin
      unique case (phase_r)
        PH_SENDREG: phase_nxt = PH_RESTART;
        PH_RESTART: phase_nxt = PH_DUMMY;
        PH_DUMMY:   phase_nxt = PH_READING;
        PH_READING: begin
          if (last_byte) begin
            phase_nxt = PH_IDLE;
          end else begin
            byte_position_nxt = byte_position_r + 8'd1;
          end
        end
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result fields
  always_comb begin
    res_o          = '0;
    res_o.ack_ctrl = ACK_NONE;
    if (item_i.func == FUNC_START) begin
      if (req_ok) begin
        res_o.accepted   = 1'b1;
        res_o.start_cond = 1'b1;
        res_o.send_valid = 1'b1;
        res_o.send_byte  = {item_i.slave_addr, 1'b0};
      end
    end else begin
      unique case (phase_r)
        PH_SENDREG: begin
          res_o.send_valid = 1'b1;
          res_o.send_byte  = register_addr_r;
        end
        PH_RESTART: begin
          res_o.restart_cond = 1'b1;
          res_o.send_valid   = 1'b1;
          res_o.send_byte    = {target_addr_r, 1'b1};
        end
        PH_DUMMY: begin
          res_o.receive_mode = 1'b1;
          res_o.ack_ctrl     = (burst_length_r == 8'd1) ? ACK_NACK : ACK_ACK;
        end
        PH_READING: begin
          res_o.ack_ctrl   = arm_nack ? ACK_NACK : ACK_NONE;
          res_o.data_valid = 1'b1;
          res_o.data_byte  = item_i.rx_byte;
          res_o.data_index = byte_position_r;
          res_o.stop_cond  = last_byte;
        end
        default: ;
      endcase
    end
    res_o.busy_now = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      target_addr_r   <= '0;
      register_addr_r <= '0;
      burst_length_r  <= '0;
      byte_position_r <= '0;
    end else if (step_i) begin
      phase_r         <= phase_nxt;
      target_addr_r   <= target_addr_nxt;
      register_addr_r <= register_addr_nxt;
      burst_length_r  <= burst_length_nxt;
      byte_position_r <= byte_position_nxt;
    end
  end

  `RRS_ASSERT(a_accept_loads, clk, rst_n, (step_i && res_o.accepted) |=> (phase_r == PH_SENDREG && byte_position_r == 8'd0), "accepted request did not load the sequence")
  `RRS_ASSERT(a_stop_ends, clk, rst_n, (step_i && res_o.stop_cond) |=> (phase_r == PH_IDLE), "stop did not end the burst")
  `RRS_NEVER(a_pos_in_range, clk, rst_n, (phase_r == PH_READING) && (burst_length_r == 8'd0 || byte_position_r >= burst_length_r), "byte position outside the burst")
  `RRS_NEVER(a_stop_needs_data, clk, rst_n, step_i && res_o.stop_cond && !res_o.data_valid, "stop without a data byte")

endmodule

[hw/rtl/i2c_rrs_out_stage.sv]
`timescale 1ns / 1ps

module i2c_rrs_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load_i,
  input  i2c_rrs_pkg::res_t                res_i,
  output logic                             ready_o,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // accepted[0], start_cond[1], restart_cond[2], send_valid[3], send_byte[11:4],
  // receive_mode[12], ack_ctrl[14:13], data_valid[15], data_byte[23:16],
  // data_index[31:24], busy_now[32], zero pad
  output logic [i2c_rrs_pkg::OutDataW-1:0] out_tdata,
  // stop_cond
  output logic                             out_tlast
);
  import i2c_rrs_pkg::*;

  logic valid_r;
  res_t res_r;

  assign ready_o    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.stop_cond;
  assign out_tdata  = {7'd0, res_r.busy_now, res_r.data_index, res_r.data_byte,
                       res_r.data_valid, res_r.ack_ctrl, res_r.receive_mode,
                       res_r.send_byte, res_r.send_valid, res_r.restart_cond,
                       res_r.start_cond, res_r.accepted};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

endmodule
